// ----- sv/kwc_pkg.sv -----
// Package for the keyword occurrence counter.
// Holds the sizing constants, operation codes and transfer payload types.
// Depends on nothing; every other file of the block imports it.
package kwc_pkg;

    localparam int NUM_KEYWORDS = 64;
    localparam int MAX_KEY_LEN  = 32;
    localparam int COUNT_WIDTH  = 16;

    localparam int BYTE_W     = 8;
    localparam int SLOT_W     = 6;
    localparam int POS_W      = 5;
    localparam int KLEN_W     = 6;
    localparam int OUT_CNT_W  = 16;

    localparam int SLOT_IDX_W = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
    localparam int POS_IDX_W  = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int SLOT_CNT_W = $clog2(NUM_KEYWORDS + 1);
    localparam int LEN_W      = $clog2(MAX_KEY_LEN + 1);

    localparam logic [LEN_W-1:0]       LEN_MAX   = LEN_W'(MAX_KEY_LEN);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_LOAD_BYTE = 2'd0,
        OP_SET_LEN   = 2'd1,
        OP_SCAN      = 2'd2,
        OP_END       = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  char_pos;
        logic [BYTE_W-1:0] byte_value;
        logic [KLEN_W-1:0] key_length;
    } req_t;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] match_count;
        logic                 count_saturated;
    } rsp_t;

    typedef logic [MAX_KEY_LEN-1:0][BYTE_W-1:0] key_row_t;

    // Byte write into the keyword memory.
    typedef struct packed {
        logic                  en;
        logic [SLOT_IDX_W-1:0] slot;
        logic [POS_IDX_W-1:0]  pos;
        logic [BYTE_W-1:0]     data;
    } key_wr_t;

    // Requests to the per-slot length and gap memories.
    typedef struct packed {
        logic                  len_wr_en;
        logic [SLOT_IDX_W-1:0] len_wr_slot;
        logic [LEN_W-1:0]      len_wr_data;
        logic                  gap_wr_en;
        logic [SLOT_IDX_W-1:0] gap_wr_slot;
        logic [LEN_W-1:0]      gap_wr_data;
        logic                  gap_clear;
        logic                  rd_en;
        logic [SLOT_IDX_W-1:0] rd_slot;
    } slot_req_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] gap;
    } slot_rd_t;

endpackage

// ----- sv/kwc_key_mem.sv -----
// Keyword byte memory: one row of MAX_KEY_LEN bytes per slot.
// Byte-wide writes, whole-row synchronous read. Depends on kwc_pkg.
module kwc_key_mem
    import kwc_pkg::*;
(
    input  logic                  clk,
    input  key_wr_t               wr,
    input  logic                  rd_en,
    input  logic [SLOT_IDX_W-1:0] rd_slot,
    output key_row_t              rd_row
);

    key_row_t mem [NUM_KEYWORDS];
    key_row_t rd_row_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.slot][wr.pos] <= wr.data;
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_slot];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

// ----- sv/kwc_slot_mem.sv -----
// Per-slot length and gap memories with registered reads.
// Valid bits give the reset values: length zero, gap at maximum. Depends on kwc_pkg.
module kwc_slot_mem
    import kwc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  slot_req_t req,
    output slot_rd_t  rd
);

    logic [LEN_W-1:0] len_mem [NUM_KEYWORDS];
    logic [LEN_W-1:0] gap_mem [NUM_KEYWORDS];

    logic [NUM_KEYWORDS-1:0] len_vld_reg;
    logic [NUM_KEYWORDS-1:0] len_vld_next;
    logic [NUM_KEYWORDS-1:0] gap_vld_reg;
    logic [NUM_KEYWORDS-1:0] gap_vld_next;

    logic [LEN_W-1:0] len_q_reg;
    logic [LEN_W-1:0] gap_q_reg;
    logic             len_qv_reg;
    logic             gap_qv_reg;

    always_comb
    begin
        len_vld_next = len_vld_reg;
        gap_vld_next = gap_vld_reg;
        if (req.len_wr_en)
        begin
            len_vld_next[req.len_wr_slot] = 1'b1;
        end
        if (req.gap_clear)
        begin
            gap_vld_next = '0;
        end
        else if (req.gap_wr_en)
        begin
            gap_vld_next[req.gap_wr_slot] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_vld_reg <= '0;
            gap_vld_reg <= '0;
            len_qv_reg  <= 1'b0;
            gap_qv_reg  <= 1'b0;
        end
        else
        begin
            len_vld_reg <= len_vld_next;
            gap_vld_reg <= gap_vld_next;
            if (req.rd_en)
            begin
                len_qv_reg <= len_vld_reg[req.rd_slot];
                gap_qv_reg <= gap_vld_reg[req.rd_slot];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.len_wr_en)
        begin
            len_mem[req.len_wr_slot] <= req.len_wr_data;
        end
        if (req.gap_wr_en)
        begin
            gap_mem[req.gap_wr_slot] <= req.gap_wr_data;
        end
        if (req.rd_en)
        begin
            len_q_reg <= len_mem[req.rd_slot];
            gap_q_reg <= gap_mem[req.rd_slot];
        end
    end

    assign rd.len = len_qv_reg ? len_q_reg : '0;
    assign rd.gap = gap_qv_reg ? gap_q_reg : LEN_MAX;

endmodule

// ----- sv/kwc_match.sv -----
// Tail comparison of one keyword row against the text history, plus gap update.
// Purely combinational; depends on kwc_pkg.
module kwc_match
    import kwc_pkg::*;
(
    input  key_row_t         key_row,
    input  key_row_t         history,
    input  logic [LEN_W-1:0] fill,
    input  slot_rd_t         slot,
    output logic             hit,
    output logic [LEN_W-1:0] gap_new
);

    key_row_t         rev;
    key_row_t         aligned;
    logic [LEN_W-1:0] shift_amt;
    logic [LEN_W-1:0] gap_inc;
    logic             bytes_eq;

    // History index zero is the newest byte. Reversing it and shifting by the
    // unused length lines text byte (len-1-k) back up with keyword byte k.
    always_comb
    begin
        for (int j = 0; j < MAX_KEY_LEN; j++)
        begin
            rev[j] = history[MAX_KEY_LEN - 1 - j];
        end
        shift_amt = LEN_MAX - slot.len;
        aligned   = rev >> {shift_amt, 3'b000};
        bytes_eq  = 1'b1;
        for (int k = 0; k < MAX_KEY_LEN; k++)
        begin
            if ((k < int'(slot.len)) && (key_row[k] != aligned[k]))
            begin
                bytes_eq = 1'b0;
            end
        end
        gap_inc = (slot.gap < LEN_MAX) ? slot.gap + LEN_W'(1) : slot.gap;
        hit     = (slot.len != '0) && (fill >= slot.len) && (gap_inc >= slot.len)
                  && bytes_eq;
        gap_new = hit ? '0 : gap_inc;
    end

endmodule

// ----- sv/keyword_occurrence_counter_top.sv -----
// Top level of the keyword occurrence counter: sequencer, text history, total.
// Instantiates kwc_key_mem, kwc_slot_mem and kwc_match; depends on kwc_pkg.
//
// Usage. Requests arrive on req/req_valid/req_ready, results leave on
// rsp/rsp_valid/rsp_ready; a transfer happens when valid and ready are high.
// Load-byte and set-length requests write the dictionary and
// produce nothing. A scan request shifts the byte into the text history and
// then walks every slot, one slot per cycle, through the keyword row memory
// and the length and gap memories: each slot is read, compared against the
// history in the following cycle and its gap written back. A scan request
// therefore keeps the block busy until the walk is done, as the slot memories have
// a single read port. An end-of-text request loads the total and saturation flag
// into the output register and clears the per-text state. The dictionary is kept.
// A waiting result does not stop loads or scans; only a second end-of-text
// request waits until the receiver has taken the previous result.
// After reset all slots are unused, the total is zero and the gaps read as the
// maximum key length through valid bits, so no clearing pass is needed.
module keyword_occurrence_counter_top
    import kwc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t                  state_reg, state_next;
    logic [SLOT_CNT_W-1:0]   slot_cnt_reg, slot_cnt_next;
    logic                    p1_vld_reg, p1_vld_next;
    logic [SLOT_IDX_W-1:0]   p1_slot_reg, p1_slot_next;
    key_row_t                hist_reg, hist_next;
    logic [LEN_W-1:0]        fill_reg, fill_next;
    logic [COUNT_WIDTH-1:0]  total_reg, total_next;
    logic                    overflow_reg, overflow_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_t                    rsp_reg, rsp_next;

    logic                    accept;
    logic                    issue;
    key_wr_t                 key_wr;
    slot_req_t               slot_req;
    slot_rd_t                slot_rd;
    key_row_t                key_row;
    logic                    hit;
    logic [LEN_W-1:0]        gap_new;
    logic [LEN_W-1:0]        len_sat;

    // The result register frees up in the same cycle it is taken.
    assign req_ready = (state_reg == ST_IDLE)
                       && ((req.op != OP_END) || !rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign issue     = (state_reg == ST_SCAN) && (slot_cnt_reg < SLOT_CNT_W'(NUM_KEYWORDS));
    assign len_sat   = (int'(req.key_length) > MAX_KEY_LEN) ? LEN_MAX
                                                            : LEN_W'(req.key_length);

    always_comb
    begin
        key_wr.en   = accept && (req.op == OP_LOAD_BYTE)
                      && (int'(req.slot) < NUM_KEYWORDS) && (int'(req.char_pos) < MAX_KEY_LEN);
        key_wr.slot = SLOT_IDX_W'(req.slot);
        key_wr.pos  = POS_IDX_W'(req.char_pos);
        key_wr.data = req.byte_value;

        slot_req.len_wr_en   = accept && (req.op == OP_SET_LEN) && (int'(req.slot) < NUM_KEYWORDS);
        slot_req.len_wr_slot = SLOT_IDX_W'(req.slot);
        slot_req.len_wr_data = len_sat;
        slot_req.gap_wr_en   = p1_vld_reg;
        slot_req.gap_wr_slot = p1_slot_reg;
        slot_req.gap_wr_data = gap_new;
        slot_req.gap_clear   = accept && (req.op == OP_END);
        slot_req.rd_en       = issue;
        slot_req.rd_slot     = SLOT_IDX_W'(slot_cnt_reg);
    end

    kwc_key_mem u_key_mem (
        .clk     (clk),
        .wr      (key_wr),
        .rd_en   (issue),
        .rd_slot (SLOT_IDX_W'(slot_cnt_reg)),
        .rd_row  (key_row)
    );

    kwc_slot_mem u_slot_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (slot_req),
        .rd    (slot_rd)
    );

    kwc_match u_match (
        .key_row (key_row),
        .history (hist_reg),
        .fill    (fill_reg),
        .slot    (slot_rd),
        .hit     (hit),
        .gap_new (gap_new)
    );

    always_comb
    begin
        state_next     = state_reg;
        slot_cnt_next  = slot_cnt_reg;
        p1_vld_next    = issue;
        p1_slot_next   = SLOT_IDX_W'(slot_cnt_reg);
        hist_next      = hist_reg;
        fill_next      = fill_reg;
        total_next     = total_reg;
        overflow_next  = overflow_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.op == OP_SCAN))
                begin
                    for (int i = MAX_KEY_LEN - 1; i > 0; i--)
                    begin
                        hist_next[i] = hist_reg[i - 1];
                    end
                    hist_next[0]  = req.byte_value;
                    fill_next     = (fill_reg < LEN_MAX) ? fill_reg + LEN_W'(1) : fill_reg;
                    slot_cnt_next = '0;
                    state_next    = ST_SCAN;
                end
                else if (accept && (req.op == OP_END))
                begin
                    rsp_next.match_count     = OUT_CNT_W'(total_reg);
                    rsp_next.count_saturated = overflow_reg;
                    rsp_valid_next           = 1'b1;
                    fill_next                = '0;
                    total_next               = '0;
                    overflow_next            = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    slot_cnt_next = slot_cnt_reg + SLOT_CNT_W'(1);
                end
                else if (!p1_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
                if (p1_vld_reg && hit)
                begin
                    if (total_reg == COUNT_MAX)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        total_next = total_reg + COUNT_WIDTH'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_cnt_reg  <= '0;
            p1_vld_reg    <= 1'b0;
            fill_reg      <= '0;
            total_reg     <= '0;
            overflow_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_cnt_reg  <= slot_cnt_next;
            p1_vld_reg    <= p1_vld_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            overflow_reg  <= overflow_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_slot_reg <= p1_slot_next;
        hist_reg    <= hist_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // A compare stage only exists while a slot walk is under way.
    assert property (@(posedge clk) disable iff (!rst_n)
        p1_vld_reg |-> (state_reg == ST_SCAN))
        else $error("compare stage active outside a scan");

    // The saturation flag is only set once the total has stuck at its maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> (total_reg == COUNT_MAX))
        else $error("saturation flag set below maximum count");

    // A scan ends only after every slot was read and written back.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && (state_next == ST_IDLE))
        |-> (slot_cnt_reg == SLOT_CNT_W'(NUM_KEYWORDS)) && !p1_vld_reg)
        else $error("scan finished before all slots were processed");

    // The history fill level never passes the maximum key length.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LEN_MAX)
        else $error("history fill out of range");
`endif

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for keyword_occurrence_counter_top.
// Holds its own dictionary and text-state predictor; depends on kwc_pkg and the block's RTL.
module testbench;
    import kwc_pkg::*;

    // The run ends here if the block stops making progress.
    localparam int unsigned RUN_LIMIT = 10_000_000;
    // A scan keeps the block busy while it walks every slot; this covers it with margin.
    localparam int unsigned SETTLE_CYCLES = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // Idle percentages for the sender and the receiver, changed per phase.
    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned texts_ended = 0;

    // Predicted state of the block: dictionary, text history, gaps and total.
    bit [BYTE_W-1:0]      key_bytes [NUM_KEYWORDS][MAX_KEY_LEN];
    int unsigned          key_len [NUM_KEYWORDS];
    bit [BYTE_W-1:0]      history [MAX_KEY_LEN];
    int unsigned          history_fill;
    int unsigned          gap [NUM_KEYWORDS];
    int unsigned          total;
    bit                   saturated;
    // Positions of each slot that have been loaded at least once. The stimulus never enables
    // a slot whose bytes are not all loaded, so an unwritten keyword byte is never compared.
    bit [MAX_KEY_LEN-1:0] key_loaded [NUM_KEYWORDS];
    // Totals expected from the end-of-text requests accepted so far, oldest first.
    rsp_t                 expected_totals [$];

    keyword_occurrence_counter_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Per-text state goes back to its starting values; the dictionary stays.
    function automatic void restart_text();
        int s;
        history_fill = 0;
        total = 0;
        saturated = 1'b0;
        for (s = 0; s < NUM_KEYWORDS; s++)
            gap[s] = MAX_KEY_LEN;
    endfunction

    // One text byte enters the history, then every slot is tried in order. A slot counts
    // when its keyword ends at this byte and no earlier counted occurrence of it overlaps.
    function automatic void shift_in_text(input bit [BYTE_W-1:0] b);
        int i;
        int s;
        int k;
        int unsigned len;
        bit hit;
        for (i = MAX_KEY_LEN - 1; i > 0; i--)
            history[i] = history[i - 1];
        history[0] = b;
        if (history_fill < MAX_KEY_LEN)
            history_fill++;
        for (s = 0; s < NUM_KEYWORDS; s++)
        begin
            len = key_len[s];
            if (gap[s] < MAX_KEY_LEN)
                gap[s]++;
            if (len != 0 && history_fill >= len && gap[s] >= len)
            begin
                // The first keyword byte lines up with the oldest of the last len text bytes.
                hit = 1'b1;
                for (k = 0; k < int'(len); k++)
                    if (key_bytes[s][k] != history[int'(len) - 1 - k])
                        hit = 1'b0;
                if (hit)
                begin
                    gap[s] = 0;
                    // Once the total holds its maximum, every further occurrence is lost
                    // and raises the flag.
                    if (total >= COUNT_MAX)
                        saturated = 1'b1;
                    else
                        total++;
                end
            end
        end
    endfunction

    // Applies one accepted request to the predicted state.
    function automatic void predict_counts(input req_t r);
        rsp_t want;
        case (r.op)
            OP_LOAD_BYTE:
                key_bytes[r.slot][r.char_pos] = r.byte_value;
            OP_SET_LEN:
                key_len[r.slot] = (r.key_length > MAX_KEY_LEN) ? MAX_KEY_LEN : r.key_length;
            OP_SCAN:
                shift_in_text(r.byte_value);
            OP_END:
            begin
                want.match_count = total[OUT_CNT_W-1:0];
                want.count_saturated = saturated;
                expected_totals.insert(expected_totals.size(), want);
                restart_text();
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    // Sends one request. The sender may idle first; once valid is raised it is held with the
    // same payload until the transfer, and the prediction is made at the accepting edge.
    // Valid is left high after the transfer so that back-to-back requests need no second
    // assignment in the same step; hold_off lowers it whenever the sender stops.
    task automatic send_request(input req_t r);
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict_counts(r);
        items_sent++;
    endtask

    // The sender stops and waits until every expected total has arrived.
    task automatic hold_off();
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_totals.size() != 0)
            @(posedge clk);
    endtask

    // Fields that the operation does not use carry random values.
    function automatic req_t make_req(input op_t op);
        req_t r;
        r.op = op;
        r.slot = SLOT_W'($urandom_range(0, 63));
        r.char_pos = POS_W'($urandom_range(0, 31));
        r.byte_value = BYTE_W'($urandom_range(0, 255));
        r.key_length = KLEN_W'($urandom_range(0, 63));
        return r;
    endfunction

    // Mostly a three-letter alphabet so that keywords actually occur, sometimes any byte.
    function automatic bit [BYTE_W-1:0] pick_byte();
        if ($urandom_range(99) < 85)
            return BYTE_W'($urandom_range(8'h61, 8'h63));
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic send_load(input logic [SLOT_W-1:0] s, input logic [POS_W-1:0] p,
                             input logic [BYTE_W-1:0] b);
        req_t r;
        r = make_req(OP_LOAD_BYTE);
        r.slot = s;
        r.char_pos = p;
        r.byte_value = b;
        key_loaded[s][p] = 1'b1;
        send_request(r);
    endtask

    // Any keyword byte below the new length that was never loaded is loaded first.
    task automatic send_length(input logic [SLOT_W-1:0] s, input logic [KLEN_W-1:0] len);
        req_t r;
        int unsigned span;
        int unsigned p;
        span = (len > MAX_KEY_LEN) ? MAX_KEY_LEN : len;
        for (p = 0; p < span; p++)
            if (!key_loaded[s][p])
                send_load(s, POS_W'(p), pick_byte());
        r = make_req(OP_SET_LEN);
        r.slot = s;
        r.key_length = len;
        send_request(r);
    endtask

    task automatic send_scan(input logic [BYTE_W-1:0] b);
        req_t r;
        r = make_req(OP_SCAN);
        r.byte_value = b;
        send_request(r);
    endtask

    task automatic send_end();
        send_request(make_req(OP_END));
        texts_ended++;
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    // The receiver stalls at random; the rate is set per phase.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Every result transfer is compared with the oldest expected total.
    always @(posedge clk)
    begin : check_results
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_totals.size() == 0)
                report_mismatch($sformatf("unexpected result count=%0d saturated=%0b",
                                          rsp.match_count, rsp.count_saturated));
            else
            begin
                want = expected_totals.pop_front();
                if (rsp.match_count !== want.match_count)
                    report_mismatch($sformatf("match_count %0d, expected %0d",
                                              rsp.match_count, want.match_count));
                if (rsp.count_saturated !== want.count_saturated)
                    report_mismatch($sformatf("count_saturated %0b, expected %0b",
                                              rsp.count_saturated, want.count_saturated));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // A text with no bytes reports zero; a second end-of-text right behind the first has to
    // wait until the receiver has taken the previous result.
    task automatic test_empty_text();
        send_end();
        send_end();
        hold_off();
    endtask

    // "aa" in slot 0 is counted without overlapping itself, "a" in the last slot counts every
    // byte, and the two keywords may overlap each other. A byte of all ones is sent before the end.
    task automatic test_overlap_rules();
        int i;
        send_load(0, 0, 8'h61);
        send_load(0, 1, 8'h61);
        send_length(0, 2);
        send_load(63, 0, 8'h61);
        send_length(63, 1);
        for (i = 0; i < 5; i++)
            send_scan(8'h61);
        send_scan(8'hFF);
        send_end();
        hold_off();
    endtask

    // Dictionary writes in the middle of a text take effect from the next byte, and the
    // slot's gap is kept across the change. Length zero switches a slot off.
    task automatic test_dictionary_change();
        int i;
        send_length(63, 0);
        for (i = 0; i < 3; i++)
            send_scan(8'h61);
        send_load(0, 1, 8'hFF);
        send_scan(8'hFF);
        send_scan(8'h61);
        send_scan(8'hFF);
        send_end();
        hold_off();
    endtask

    // All slots hold the one-byte keyword zero, so each zero byte counts 64 times. The total
    // reaches exactly its maximum with one slot switched off, then the next byte overflows.
    task automatic test_count_saturation();
        int s;
        int i;
        for (s = 0; s < NUM_KEYWORDS; s++)
        begin
            send_load(SLOT_W'(s), 0, 8'h00);
            send_length(SLOT_W'(s), 1);
        end
        for (i = 0; i < 1023; i++)
            send_scan(8'h00);
        send_length(63, 0);
        send_scan(8'h00);
        send_length(63, 1);
        send_scan(8'h00);
        send_end();
        hold_off();
        for (s = 0; s < NUM_KEYWORDS; s++)
            send_length(SLOT_W'(s), 0);
    endtask

    // One random dictionary change: a new keyword of random length, a disable, an overlong
    // length, or a stray byte load anywhere in the dictionary.
    task automatic edit_dictionary();
        logic [SLOT_W-1:0] s;
        int unsigned sel;
        int unsigned len;
        int unsigned p;
        s = SLOT_W'($urandom_range(0, 63));
        sel = $urandom_range(99);
        if (sel < 10)
        begin
            send_load(s, POS_W'($urandom_range(0, 31)), BYTE_W'($urandom_range(0, 255)));
        end
        else
        begin
            if (sel < 55)
                len = $urandom_range(1, 3);
            else if (sel < 78)
                len = $urandom_range(4, 8);
            else if (sel < 86)
                len = $urandom_range(9, 32);
            else if (sel < 94)
                len = 0;
            else
                len = $urandom_range(33, 63);
            for (p = 0; p < len && p < MAX_KEY_LEN; p++)
                if ($urandom_range(99) < 70)
                    send_load(s, POS_W'(p), pick_byte());
            send_length(s, KLEN_W'(len));
        end
    endtask

    // Repeats a slot's keyword into the text so that long keywords get counted too.
    task automatic echo_keyword(input logic [SLOT_W-1:0] s);
        int unsigned k;
        if (key_len[s] == 0)
            send_scan(pick_byte());
        else
            for (k = 0; k < key_len[s]; k++)
                send_scan(key_bytes[s][k]);
    endtask

    // One text: a few dictionary edits, then bytes with now and then a keyword copied in or
    // a dictionary change mid-text, then the end-of-text request.
    task automatic random_text();
        int unsigned n;
        int unsigned i;
        n = $urandom_range(0, 2);
        for (i = 0; i < n; i++)
            edit_dictionary();
        if ($urandom_range(99) < 5)
            hold_off();
        n = $urandom_range(0, 10);
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 5)
                edit_dictionary();
            if ($urandom_range(99) < 20)
                echo_keyword(SLOT_W'($urandom_range(0, 63)));
            else
                send_scan(pick_byte());
        end
        send_end();
    endtask

    task automatic run_random_phase(input int unsigned n_items, input int unsigned tx_idle,
                                    input int unsigned rx_idle);
        int unsigned first_item;
        int unsigned first_text;
        send_idle = tx_idle;
        recv_idle = rx_idle;
        // The sender pauses at each phase change until every result is back.
        hold_off();
        first_item = items_sent;
        first_text = texts_ended;
        while (items_sent - first_item < n_items || texts_ended - first_text < 12)
            random_text();
    endtask

    task automatic test_random_texts();
        run_random_phase(250, 13, 63);
        run_random_phase(250, 63, 13);
        run_random_phase(200, 0, 0);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        restart_text();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_text();
        test_overlap_rules();
        test_dictionary_change();
        test_count_saturation();
        test_random_texts();
        hold_off();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
